[src/ccs_pkg.sv]
// Shared types and constants for the column chunk store.
`default_nettype none

package ccs_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 4096;

  localparam int unsigned CNT_W    = 13;  // counter and capacity width
  localparam int unsigned CAP_W    = 17;  // compare width covering capacity and depth
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned SLOT_W   = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

  // command queue between front and back
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_LVL_W = $clog2(CQ_DEPTH + 1);

  // result queue at the output
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_LVL_W = $clog2(RQ_DEPTH + 1);

  // column type codes
  localparam logic [1:0] TYPE_INT32  = 2'd0;
  localparam logic [1:0] TYPE_INT64  = 2'd1;
  localparam logic [1:0] TYPE_DOUBLE = 2'd2;
  localparam logic [1:0] TYPE_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_COLUMN_TYPE = 2'd0;
  localparam logic [1:0] CFG_NULLABLE    = 2'd1;
  localparam logic [1:0] CFG_CAPACITY    = 2'd2;

  typedef enum logic [1:0] {
    CMD_APPEND      = 2'd0,
    CMD_APPEND_NULL = 2'd1,
    CMD_GET         = 2'd2,
    CMD_CLEAR       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TYPE    = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOTNULL = 3'd3,
    ST_RANGE   = 3'd4,
    ST_NULL    = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]       column_type;
    logic             nullable;
    logic [CNT_W-1:0] capacity;
  } cfg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              type_ok;
    logic [VAL_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
  } cmdq_entry_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] stored_count;
    logic [CNT_W-1:0] null_total;
    logic             any_nulls;
    logic             page_full;
    logic             stats_valid;
    logic [VAL_W-1:0] min_value;
    logic [VAL_W-1:0] max_value;
  } result_t;

endpackage

`default_nettype wire

[src/ccs_front.sv]
// Front end: accept transactions, check type, normalize value, queue commands.
`default_nettype none

module ccs_front
  import ccs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic [1:0]               in_cmd,
  input  wire logic [1:0]               in_expected_type,
  input  wire logic signed [VAL_W-1:0]  in_value_bits,
  input  wire logic [SLOT_W-1:0]        in_slot_index,
  output logic                          cq_valid,
  output cmdq_entry_t                   cq_head,
  input  wire logic                     cq_pop
);

  cmdq_entry_t          entry_r [CQ_DEPTH];
  cmdq_entry_t          new_entry;
  logic [CQ_AW-1:0]     wr_ptr_r;
  logic [CQ_AW-1:0]     rd_ptr_r;
  logic [CQ_LVL_W-1:0]  count_r;
  logic [CQ_LVL_W-1:0]  count_nxt;
  logic                 push_ok;
  logic                 pop_ok;

  assign in_full  = (count_r == CQ_LVL_W'(CQ_DEPTH));
  assign cq_valid = (count_r != '0);
  assign cq_head  = entry_r[rd_ptr_r];
  assign push_ok  = in_push && !in_full;
  assign pop_ok   = cq_pop && cq_valid;

  // classify: type check and int32 sign extension against current config
  always_comb begin
    new_entry.cmd     = cmd_t'(in_cmd);
    new_entry.type_ok = (cfg.column_type == in_expected_type) &&
                        (cfg.column_type != TYPE_NONE);
    new_entry.slot    = in_slot_index;
    if (cfg.column_type == TYPE_INT32) begin
      new_entry.value = {{32{in_value_bits[31]}}, in_value_bits[31:0]};
    end else begin
      new_entry.value = in_value_bits;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entry_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

`default_nettype wire

[src/ccs_back.sv]
// Back end: execute commands against the slot store, counters and zone map.
`default_nettype none

module ccs_back
  import ccs_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg,
  input  wire logic                 cq_valid,
  input  wire cmdq_entry_t          cq_head,
  output logic                      cq_pop,
  input  wire logic [RQ_LVL_W-1:0]  rq_level,
  output logic                      res_push,
  output result_t                   res
);

  localparam int unsigned AW = $clog2(MAX_SLOTS);

  // store word: null mark on top, value below
  logic [VAL_W:0]      mem [MAX_SLOTS];
  logic [VAL_W:0]      rd_data_r;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [VAL_W:0]      wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    ncnt_r, ncnt_nxt;
  logic                any_null_r, any_null_nxt;
  logic [VAL_W-1:0]    min_r, min_nxt;
  logic [VAL_W-1:0]    max_r, max_nxt;

  logic                r_valid_r;
  status_t             r_status_r;
  logic                r_get_r;
  status_t             status_e;
  logic                get_e;

  logic [RQ_LVL_W:0]   rq_used;
  logic                fire;
  logic [CAP_W-1:0]    eff_cap;
  logic                full;
  logic                lt_min;
  logic                lt_max;
  logic                is_null;

  function automatic logic is_nan(input logic [VAL_W-1:0] b);
    return b[62:0] > 63'h7FF0_0000_0000_0000;
  endfunction

  function automatic logic [VAL_W-1:0] dbl_key(input logic [VAL_W-1:0] b);
    return b[63] ? ~b : {1'b1, b[62:0]};
  endfunction

  // a < b in the order of the column type
  function automatic logic less_than(input logic [1:0] ctype,
                                     input logic [VAL_W-1:0] a,
                                     input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] ab;
    ab = a | b;
    if (ctype == TYPE_DOUBLE) begin
      if (is_nan(a) || is_nan(b) || (ab[62:0] == '0)) begin
        return 1'b0;
      end
      return dbl_key(a) < dbl_key(b);
    end
    return {~a[63], a[62:0]} < {~b[63], b[62:0]};
  endfunction

  // hold back unless the result queue has room for this one and any in flight
  assign rq_used = {1'b0, rq_level} + {{RQ_LVL_W{1'b0}}, r_valid_r};
  assign fire    = cq_valid && (rq_used < (RQ_LVL_W + 1)'(RQ_DEPTH));
  assign cq_pop  = fire;

  assign eff_cap = (CAP_W'(cfg.capacity) < CAP_W'(MAX_SLOTS)) ?
                   CAP_W'(cfg.capacity) : CAP_W'(MAX_SLOTS);
  assign full    = CAP_W'(cnt_r) >= eff_cap;
  assign lt_min  = less_than(cfg.column_type, cq_head.value, min_r);
  assign lt_max  = less_than(cfg.column_type, max_r, cq_head.value);
  assign wr_addr = AW'(cnt_r);
  assign rd_addr = AW'(cq_head.slot);

  always_comb begin
    cnt_nxt      = cnt_r;
    ncnt_nxt     = ncnt_r;
    any_null_nxt = any_null_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    wr_en        = 1'b0;
    wr_data      = '0;
    rd_en        = 1'b0;
    get_e        = 1'b0;
    status_e     = ST_OK;
    if (fire) begin
      unique case (cq_head.cmd)
        CMD_APPEND: begin
          if (!cq_head.type_ok) begin
            status_e = ST_TYPE;
          end else if (full) begin
            status_e = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_data = {1'b0, cq_head.value};
            if (cnt_r == ncnt_r) begin
              min_nxt = cq_head.value;
              max_nxt = cq_head.value;
            end else begin
              if (lt_min) min_nxt = cq_head.value;
              if (lt_max) max_nxt = cq_head.value;
            end
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        CMD_APPEND_NULL: begin
          if (!cfg.nullable) begin
            status_e = ST_NOTNULL;
          end else if (full) begin
            status_e = ST_FULL;
          end else begin
            wr_en        = 1'b1;
            wr_data      = {1'b1, {VAL_W{1'b0}}};
            ncnt_nxt     = ncnt_r + 1'b1;
            cnt_nxt      = cnt_r + 1'b1;
            any_null_nxt = 1'b1;
          end
        end
        CMD_GET: begin
          if (!cq_head.type_ok) begin
            status_e = ST_TYPE;
          end else if ((cq_head.slot >= SLOT_W'(cnt_r)) ||
                       (CAP_W'(cq_head.slot) >= CAP_W'(MAX_SLOTS))) begin
            status_e = ST_RANGE;
          end else begin
            rd_en = 1'b1;
            get_e = 1'b1;
          end
        end
        CMD_CLEAR: begin
          cnt_nxt      = '0;
          ncnt_nxt     = '0;
          any_null_nxt = 1'b0;
          min_nxt      = '0;
          max_nxt      = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ncnt_r     <= '0;
      any_null_r <= 1'b0;
      min_r      <= '0;
      max_r      <= '0;
      r_valid_r  <= 1'b0;
      r_get_r    <= 1'b0;
      r_status_r <= ST_OK;
    end else begin
      cnt_r      <= cnt_nxt;
      ncnt_r     <= ncnt_nxt;
      any_null_r <= any_null_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      r_valid_r  <= fire;
      r_get_r    <= get_e;
      r_status_r <= status_e;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result stage: state registers already hold the post-command values
  assign is_null  = rd_data_r[VAL_W];
  assign res_push = r_valid_r;

  always_comb begin
    res.status       = r_status_r;
    res.read_value   = '0;
    if (r_get_r) begin
      if (is_null) begin
        res.status = ST_NULL;
      end else begin
        res.read_value = rd_data_r[VAL_W-1:0];
      end
    end
    res.stored_count = cnt_r;
    res.null_total   = ncnt_r;
    res.any_nulls    = any_null_r;
    res.page_full    = full;
    res.stats_valid  = (cnt_r != ncnt_r);
    res.min_value    = min_r;
    res.max_value    = max_r;
  end

endmodule

`default_nettype wire

[src/ccs_resq.sv]
// Result queue: holds finished results until the consumer pops them.
`default_nettype none

module ccs_resq
  import ccs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 res_push,
  input  wire result_t              res,
  output logic [RQ_LVL_W-1:0]       rq_level,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output result_t                   head
);

  result_t              entry_r [RQ_DEPTH];
  logic [RQ_AW-1:0]     wr_ptr_r;
  logic [RQ_AW-1:0]     rd_ptr_r;
  logic [RQ_LVL_W-1:0]  count_r;
  logic [RQ_LVL_W-1:0]  count_nxt;
  logic                 pop_ok;

  assign rq_level  = count_r;
  assign out_empty = (count_r == '0);
  assign head      = entry_r[rd_ptr_r];
  assign pop_ok    = out_pop && !out_empty;

  always_comb begin
    count_nxt = count_r;
    if (res_push && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !res_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (res_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      entry_r[wr_ptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

[src/column_chunk_store_with_zone_map.sv]
// Top level of the typed column chunk store with null marks and min/max zone map.
`default_nettype none

//  Channel  Handshake           Payload
//  in_      in_push / in_full   cmd, expected_type, value_bits, slot_index
//  out_     out_pop / out_empty status, read_value, counters, flags, min/max
//  cfg_     cfg_valid/cfg_ready cfg_index (0 type, 1 nullable, 2 capacity), cfg_data
//
//  One command per cycle while the result queue has room, one slot store write or
//  read each: a result passes the command queue, the back end and the result queue.
//  Reset clears counters, zone map, queues and config, not the slot store:
//  only slots below the entry count are ever read. cfg_ready stays high.
//  Hold the back end while queued plus in-flight results fill the result
//  queue; the command queue then fills and raises in_full.

module column_chunk_store_with_zone_map
  import ccs_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command channel
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic [1:0]               in_cmd,
  input  wire logic [1:0]               in_expected_type,
  input  wire logic signed [VAL_W-1:0]  in_value_bits,
  input  wire logic [SLOT_W-1:0]        in_slot_index,
  // result channel
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic [2:0]                    out_status,
  output logic signed [VAL_W-1:0]       out_read_value,
  output logic [CNT_W-1:0]              out_stored_count,
  output logic [CNT_W-1:0]              out_null_total,
  output logic                          out_any_nulls,
  output logic                          out_page_full,
  output logic                          out_stats_valid,
  output logic signed [VAL_W-1:0]       out_min_value,
  output logic signed [VAL_W-1:0]       out_max_value,
  // configuration channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [CNT_W-1:0]         cfg_data
);

  cfg_t                 cfg_r;
  logic                 cq_valid;
  cmdq_entry_t          cq_head;
  logic                 cq_pop;
  logic [RQ_LVL_W-1:0]  rq_level;
  logic                 rq_push;
  result_t              rq_in;
  result_t              rq_head;

  // Config writes must land only while the block is idle; the block does not enforce this and takes them always.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.column_type <= TYPE_INT32;
      cfg_r.nullable    <= 1'b0;
      cfg_r.capacity    <= CAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COLUMN_TYPE: cfg_r.column_type <= cfg_data[1:0];
        CFG_NULLABLE:    cfg_r.nullable    <= cfg_data[0];
        CFG_CAPACITY:    cfg_r.capacity    <= cfg_data;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Front: accept and classify into the command queue.
  ccs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_cmd           (in_cmd),
    .in_expected_type (in_expected_type),
    .in_value_bits    (in_value_bits),
    .in_slot_index    (in_slot_index),
    .cq_valid         (cq_valid),
    .cq_head          (cq_head),
    .cq_pop           (cq_pop)
  );

  // Back: execute against store, counters and zone map.
  ccs_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cq_valid (cq_valid),
    .cq_head  (cq_head),
    .cq_pop   (cq_pop),
    .rq_level (rq_level),
    .res_push (rq_push),
    .res      (rq_in)
  );

  // Result queue: decouple the consumer from the back end.
  ccs_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (rq_push),
    .res       (rq_in),
    .rq_level  (rq_level),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .head      (rq_head)
  );

  assign out_status       = rq_head.status;
  assign out_read_value   = rq_head.read_value;
  assign out_stored_count = rq_head.stored_count;
  assign out_null_total   = rq_head.null_total;
  assign out_any_nulls    = rq_head.any_nulls;
  assign out_page_full    = rq_head.page_full;
  assign out_stats_valid  = rq_head.stats_valid;
  assign out_min_value    = rq_head.min_value;
  assign out_max_value    = rq_head.max_value;

  // Credit check must keep the result queue from overflowing.
  a_rq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rq_push |-> (rq_level < RQ_LVL_W'(RQ_DEPTH) || (out_pop && !out_empty)))
    else $error("result queue overflow");

  // Nulls are a subset of all entries.
  a_null_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_null_total <= out_stored_count)
    else $error("null count exceeds entry count");

  // Without a non-null value the zone map stays zero.
  a_zone_map_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_stats_valid) |-> (out_min_value == '0 && out_max_value == '0))
    else $error("zone map set without values");

  // A get that reads a value reports it only with status ok.
  a_read_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |-> out_read_value == '0)
    else $error("read value with failing status");

endmodule

`default_nettype wire

[tb/column_chunk_store_with_zone_map_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the column chunk store: directed and random commands against a predictor.

module column_chunk_store_with_zone_map_tb;
  import ccs_pkg::*;

  // Predicts each result from its own copy of the page and the registers.
  class chunk_scoreboard;
    logic [1:0]       col_type;
    logic             nullable;
    logic [CNT_W-1:0] capacity;
    logic [VAL_W-1:0] slot_value [MAX_SLOTS_DEF];
    bit               slot_is_null [MAX_SLOTS_DEF];
    int unsigned      entries;
    int unsigned      null_entries;
    bit               has_null;
    logic [VAL_W-1:0] zone_min;
    logic [VAL_W-1:0] zone_max;
    result_t          awaited [$];
    int               errors;

    function new();
      col_type = TYPE_INT32;
      nullable = 1'b0;
      capacity = CAP_RESET;
      errors   = 0;
      clear_page();
    endfunction

    function void clear_page();
      entries      = 0;
      null_entries = 0;
      has_null     = 1'b0;
      zone_min     = '0;
      zone_max     = '0;
    endfunction

    function void write_register(logic [1:0] index, logic [CNT_W-1:0] data);
      case (index)
        CFG_COLUMN_TYPE: col_type = data[1:0];
        CFG_NULLABLE:    nullable = data[0];
        CFG_CAPACITY:    capacity = data;
        default: ;
      endcase
    endfunction

    function int unsigned usable_slots();
      return (capacity < MAX_SLOTS_DEF) ? capacity : MAX_SLOTS_DEF;
    endfunction

    function bit is_nan(logic [VAL_W-1:0] b);
      return b[62:0] > 63'h7FF0_0000_0000_0000;
    endfunction

    // Map IEEE bits onto an unsigned key that sorts like the values.
    function logic [VAL_W-1:0] order_key(logic [VAL_W-1:0] b);
      return b[63] ? ~b : (b | 64'h8000_0000_0000_0000);
    endfunction

    function bit precedes(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      if (col_type == TYPE_DOUBLE) begin
        if (is_nan(a) || is_nan(b)) return 1'b0;
        if ((a[62:0] | b[62:0]) == '0) return 1'b0;
        return order_key(a) < order_key(b);
      end
      return $signed(a) < $signed(b);
    endfunction

    function void note_command(cmd_t cmd, logic [1:0] etype, logic [VAL_W-1:0] value,
                               logic [SLOT_W-1:0] slot);
      result_t     r;
      logic [VAL_W-1:0] v;
      bit          type_ok;
      bit          full;
      type_ok  = (col_type == etype) && (col_type != TYPE_NONE);
      full     = entries >= usable_slots();
      r        = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_APPEND: begin
          if (!type_ok) r.status = ST_TYPE;
          else if (full) r.status = ST_FULL;
          else begin
            v = value;
            if (col_type == TYPE_INT32) v = {{32{value[31]}}, value[31:0]};
            slot_value[entries] = v;
            if (entries == null_entries) begin
              zone_min = v;
              zone_max = v;
            end else begin
              if (precedes(v, zone_min)) zone_min = v;
              if (precedes(zone_max, v)) zone_max = v;
            end
            slot_is_null[entries] = 1'b0;
            entries++;
          end
        end
        CMD_APPEND_NULL: begin
          if (!nullable) r.status = ST_NOTNULL;
          else if (full) r.status = ST_FULL;
          else begin
            slot_value[entries]   = '0;
            slot_is_null[entries] = 1'b1;
            null_entries++;
            has_null = 1'b1;
            entries++;
          end
        end
        CMD_GET: begin
          if (!type_ok) r.status = ST_TYPE;
          else if (slot >= entries || slot >= MAX_SLOTS_DEF) r.status = ST_RANGE;
          else if (slot_is_null[slot]) r.status = ST_NULL;
          else r.read_value = slot_value[slot];
        end
        default: clear_page();
      endcase
      r.stored_count = entries[CNT_W-1:0];
      r.null_total   = null_entries[CNT_W-1:0];
      r.any_nulls    = has_null;
      r.page_full    = entries >= usable_slots();
      r.stats_valid  = entries != null_entries;
      r.min_value    = zone_min;
      r.max_value    = zone_max;
      awaited.push_back(r);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report("unexpected result status", got.status, '0);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)             report("status", got.status, want.status);
      if (got.read_value !== want.read_value)     report("read_value", got.read_value,
                                                         want.read_value);
      if (got.stored_count !== want.stored_count) report("stored_count", got.stored_count,
                                                         want.stored_count);
      if (got.null_total !== want.null_total)     report("null_total", got.null_total,
                                                         want.null_total);
      if (got.any_nulls !== want.any_nulls)       report("any_nulls", got.any_nulls,
                                                         want.any_nulls);
      if (got.page_full !== want.page_full)       report("page_full", got.page_full,
                                                         want.page_full);
      if (got.stats_valid !== want.stats_valid)   report("stats_valid", got.stats_valid,
                                                         want.stats_valid);
      if (got.min_value !== want.min_value)       report("min_value", got.min_value,
                                                         want.min_value);
      if (got.max_value !== want.max_value)       report("max_value", got.max_value,
                                                         want.max_value);
    endtask
  endclass

  // Clock, reset and every block input start at known values.
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_push = 1'b0;
  logic [1:0]              in_cmd = '0;
  logic [1:0]              in_expected_type = '0;
  logic [VAL_W-1:0]        in_value_bits = '0;
  logic [SLOT_W-1:0]       in_slot_index = '0;
  logic                    out_pop = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [1:0]              cfg_index = '0;
  logic [CNT_W-1:0]        cfg_data = '0;

  wire                     in_full;
  wire                     out_empty;
  wire [2:0]               out_status;
  wire signed [VAL_W-1:0]  out_read_value;
  wire [CNT_W-1:0]         out_stored_count;
  wire [CNT_W-1:0]         out_null_total;
  wire                     out_any_nulls;
  wire                     out_page_full;
  wire                     out_stats_valid;
  wire signed [VAL_W-1:0]  out_min_value;
  wire signed [VAL_W-1:0]  out_max_value;
  wire                     cfg_ready;

  chunk_scoreboard chunks = new();

  always #1 clk = ~clk;

  column_chunk_store_with_zone_map dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_cmd           (in_cmd),
    .in_expected_type (in_expected_type),
    .in_value_bits    (in_value_bits),
    .in_slot_index    (in_slot_index),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_read_value   (out_read_value),
    .out_stored_count (out_stored_count),
    .out_null_total   (out_null_total),
    .out_any_nulls    (out_any_nulls),
    .out_page_full    (out_page_full),
    .out_stats_valid  (out_stats_valid),
    .out_min_value    (out_min_value),
    .out_max_value    (out_max_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Result side: check every transaction taken at this edge, then pick the
  // next pop level. At the start of each period the stall pattern is drawn from
  // always-ready, coin toss, one-in-four and a hold-off early in the period.
  int unsigned pop_cycle = 0;
  int unsigned pop_mode = 0;

  always @(posedge clk) begin
    result_t seen;
    if (rst_n && out_pop && !out_empty) begin
      seen.status       = status_t'(out_status);
      seen.read_value   = out_read_value;
      seen.stored_count = out_stored_count;
      seen.null_total   = out_null_total;
      seen.any_nulls    = out_any_nulls;
      seen.page_full    = out_page_full;
      seen.stats_valid  = out_stats_valid;
      seen.min_value    = out_min_value;
      seen.max_value    = out_max_value;
      chunks.check_result(seen);
    end
    pop_cycle++;
    if (pop_cycle % 64 == 0) pop_mode = $urandom_range(0, 3);
    case (pop_mode)
      0:       out_pop <= 1'b1;
      1:       out_pop <= 1'($urandom_range(0, 1));
      2:       out_pop <= ($urandom_range(0, 3) == 0);
      default: out_pop <= (pop_cycle % 64) >= 40;
    endcase
  end

  // Command side: bursts of random length, separated by random gaps, so that
  // idle cycles land on every phase of the back end. Long bursts give
  // stretches with no idling at all.
  int burst_left = 0;

  task automatic issue(cmd_t cmd, logic [1:0] etype, logic [VAL_W-1:0] value,
                       logic [SLOT_W-1:0] slot);
    if (burst_left == 0) begin
      in_push <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_push          <= 1'b1;
    in_cmd           <= cmd;
    in_expected_type <= etype;
    in_value_bits    <= value;
    in_slot_index    <= slot;
    // hold the command until the queue takes it
    do @(posedge clk); while (in_full);
    chunks.note_command(cmd, etype, value, slot);
    burst_left--;
  endtask

  // Drop push and wait until every predicted result has been popped, then
  // let the path through the block settle.
  task automatic hold_until_drained();
    in_push <= 1'b0;
    burst_left = 0;
    while (chunks.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all three registers back to back; call only while the block is idle.
  task automatic program_page(logic [1:0] ctype, logic nbl, logic [CNT_W-1:0] cap);
    logic [1:0]       regs [3];
    logic [CNT_W-1:0] data [3];
    regs[0] = CFG_COLUMN_TYPE;
    regs[1] = CFG_NULLABLE;
    regs[2] = CFG_CAPACITY;
    // unused upper data bits carry junk now and then; the block must ignore it
    data[0] = {($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'd0, ctype};
    data[1] = {($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'd0, nbl};
    data[2] = cap;
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= data[i];
      do @(posedge clk); while (!cfg_ready);
      chunks.write_register(regs[i], data[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] specials [8];
    specials = '{64'h7FF8_0000_0000_0000,   // quiet NaN
                 64'h7FF0_0000_0000_0001,   // signaling NaN
                 64'hFFF8_0000_0000_0000,   // negative NaN
                 64'h7FF0_0000_0000_0000,   // +inf
                 64'hFFF0_0000_0000_0000,   // -inf
                 64'h0000_0000_0000_0000,   // +0
                 64'h8000_0000_0000_0000,   // -0
                 64'h3FF0_0000_0000_0000};  // 1.0
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 3))
           0:       return 64'h8000_0000_0000_0000;
           1:       return 64'h7FFF_FFFF_FFFF_FFFF;
           2:       return '0;
           default: return '1;
         endcase
      1: return specials[$urandom_range(0, 7)];
      2: return 64'(int'($urandom_range(0, 10)) - 5);
      // doubles of modest magnitude so that min and max move often
      3: return {1'($urandom), 11'(11'h3FC + $urandom_range(0, 6)), 20'($urandom), $urandom};
      // int32 extremes under random upper bits
      4: return {$urandom, ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly well-typed commands with reads aimed near the fill level.
  task automatic random_item();
    cmd_t              cmd;
    logic [1:0]        etype;
    logic [SLOT_W-1:0] slot;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      cmd = CMD_APPEND;
    else if (roll < 62) cmd = CMD_APPEND_NULL;
    else if (roll < 96) cmd = CMD_GET;
    else                cmd = CMD_CLEAR;
    etype = ($urandom_range(0, 9) == 0) ? 2'($urandom) : chunks.col_type;
    case ($urandom_range(0, 9))
      0:       slot = 16'($urandom);
      1:       slot = 16'hFFFF;
      default: slot = 16'($urandom_range(0, chunks.entries + 1));
    endcase
    issue(cmd, etype, pick_value(), slot);
  endtask

  initial begin
    int               random_sent;
    int               phase;
    int               phase_len;
    logic [1:0]       ctype;
    logic             nbl;
    logic [CNT_W-1:0] cap;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: int32, not nullable, full depth.
    issue(CMD_GET, TYPE_INT32, '0, 16'd0);                      // empty page, out of range
    issue(CMD_APPEND, TYPE_INT32, 64'hDEAD_BEEF_7FFF_FFFF, '0); // int32 max, upper bits dropped
    issue(CMD_APPEND, TYPE_INT32, 64'h0123_4567_8000_0000, '0); // int32 min, sign extended
    issue(CMD_APPEND, TYPE_INT64, 64'd1, '0);                   // type mismatch
    issue(CMD_APPEND, TYPE_NONE, 64'd1, '0);                    // type code three never matches
    issue(CMD_APPEND_NULL, TYPE_INT32, '0, '0);                 // column not nullable
    issue(CMD_GET, TYPE_INT32, '0, 16'd1);
    issue(CMD_GET, TYPE_INT32, '0, 16'd2);                      // at the count, one past the last entry
    issue(CMD_GET, TYPE_INT32, '1, 16'hFFFF);
    issue(CMD_GET, TYPE_DOUBLE, '0, 16'd0);                     // read with the wrong type
    issue(CMD_CLEAR, TYPE_INT32, '0, '0);

    // Nullable double page of four slots: signed zeros, nulls, fill to full.
    hold_until_drained();
    program_page(TYPE_DOUBLE, 1'b1, 13'd4);
    issue(CMD_APPEND, TYPE_DOUBLE, 64'h0000_0000_0000_0000, '0);
    issue(CMD_APPEND, TYPE_DOUBLE, 64'h8000_0000_0000_0000, '0); // -0 ties with +0
    issue(CMD_APPEND_NULL, TYPE_INT64, '1, '0);                  // expected type ignored
    issue(CMD_APPEND, TYPE_DOUBLE, 64'hFFF0_0000_0000_0000, '0); // -inf fills the page
    issue(CMD_APPEND, TYPE_DOUBLE, 64'h7FF8_0000_0000_0000, '0); // full
    issue(CMD_APPEND_NULL, TYPE_DOUBLE, '0, '0);                 // full
    issue(CMD_GET, TYPE_DOUBLE, '0, 16'd2);                      // null slot
    issue(CMD_GET, TYPE_DOUBLE, '0, 16'd1);
    issue(CMD_GET, TYPE_DOUBLE, '0, 16'd3);
    // NaN as the first value pins min and max
    issue(CMD_CLEAR, TYPE_DOUBLE, '0, '0);
    issue(CMD_APPEND, TYPE_DOUBLE, 64'h7FF8_0000_0000_0000, '0);
    issue(CMD_APPEND, TYPE_DOUBLE, 64'h3FF0_0000_0000_0000, '0);

    // Type code three in the register and a capacity of zero.
    hold_until_drained();
    program_page(TYPE_NONE, 1'b1, 13'd0);
    issue(CMD_APPEND, TYPE_NONE, 64'd7, '0);
    issue(CMD_GET, TYPE_NONE, '0, 16'd0);
    issue(CMD_APPEND_NULL, TYPE_NONE, '0, '0);                   // zero capacity is always full

    // Random phases. The first few pin the register extremes; pages are not
    // always cleared between phases, so old bits meet new register values.
    random_sent = 0;
    phase = 0;
    while (random_sent < 400) begin
      hold_until_drained();
      case (phase)
        0: begin ctype = TYPE_INT64;  nbl = 1'b1; cap = 13'd1;    end
        1: begin ctype = TYPE_INT32;  nbl = 1'b1; cap = 13'd8191; end
        2: begin ctype = TYPE_DOUBLE; nbl = 1'b0; cap = 13'd4096; end
        3: begin ctype = TYPE_INT64;  nbl = 1'b0; cap = 13'd0;    end
        default: begin
          ctype = ($urandom_range(0, 15) == 0) ? TYPE_NONE : 2'($urandom_range(0, 2));
          nbl = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 9))
            6:       cap = 13'd0;
            7:       cap = 13'd4096;
            8:       cap = 13'd8191;
            9:       cap = 13'($urandom);
            default: cap = 13'($urandom_range(1, 40));
          endcase
        end
      endcase
      program_page(ctype, nbl, cap);
      if ($urandom_range(0, 1)) begin
        issue(CMD_CLEAR, chunks.col_type, '0, '0);
        random_sent++;
      end
      phase_len = $urandom_range(20, 60);
      for (int k = 0; k < phase_len; k++) begin
        // once, stop sending mid-phase until the result queue runs dry
        if (phase == 4 && k == phase_len / 2) hold_until_drained();
        random_item();
        random_sent++;
      end
      phase++;
    end

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (chunks.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[column_chunk_store_with_zone_map.f]
src/ccs_pkg.sv
src/ccs_front.sv
src/ccs_back.sv
src/ccs_resq.sv
src/column_chunk_store_with_zone_map.sv
tb/column_chunk_store_with_zone_map_tb.sv
